[sv/wormhole_output_stage_arbiter_macros.svh]
// ----------------------------------------------------------------------------
// Wormhole output stage arbiter assertion macros
// Concurrent assertion shorthands clocked on i_clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef WORMHOLE_OUTPUT_STAGE_ARBITER_MACROS_SVH
`define WORMHOLE_OUTPUT_STAGE_ARBITER_MACROS_SVH

// same-cycle implication
`define WOSA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define WOSA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/wosa_pkg.sv]
// ----------------------------------------------------------------------------
// Wormhole output stage arbiter package
// Transaction types, field codes and default sizes shared by the block.
// ----------------------------------------------------------------------------
package wosa_pkg;

    localparam int NUM_INPUTS_DEF  = 4;
    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int DATA_WIDTH_DEF  = 32;

    localparam logic       ACT_ARRIVAL = 1'b0;
    localparam logic       ACT_TICK    = 1'b1;

    localparam int         KIND_HEAD_BIT = 0;
    localparam int         KIND_TAIL_BIT = 1;

    localparam logic [0:0] CFG_PACKET_LENGTH   = 1'b0;
    localparam logic [0:0] CFG_LOCAL_DIRECTION = 1'b1;

    localparam logic [3:0] PKT_LEN_RST = 4'd4;
    localparam logic [4:0] HDR_MAX     = 5'd31;

    typedef struct packed {
        logic        action;
        logic [1:0]  port;
        logic [1:0]  flit_kind;
        logic [31:0] flit_data;
        logic        downstream_stop;
    } t_in;

    typedef struct packed {
        logic        out_valid;
        logic [1:0]  out_port;
        logic [1:0]  out_kind;
        logic [31:0] out_data;
        logic [3:0]  stop_mask;
        logic        port_can_accept_packet;
        logic        overflow;
    } t_out;

    typedef struct packed {
        logic push;
        logic pop;
    } t_fifo_ctl;

endpackage

[sv/wosa_fifo.sv]
// ----------------------------------------------------------------------------
// Wormhole output stage flit queue
// One port's flit FIFO with a registered head entry read ahead of the pop.
// ----------------------------------------------------------------------------
module wosa_fifo
    import wosa_pkg::*;
#(
    parameter int DEPTH      = QUEUE_DEPTH_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    localparam int AW = $clog2(DEPTH),
    localparam int CW = $clog2(DEPTH + 1),
    localparam int EW = DATA_WIDTH + 2
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_fifo_ctl     i_ctl,
    input  logic [EW-1:0] i_wr_entry,
    output logic [EW-1:0] o_head,
    output logic [CW-1:0] o_count
);

    logic [EW-1:0] r_mem [DEPTH];
    logic [AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [CW-1:0] r_count, n_count;
    logic [EW-1:0] r_head;
    logic          do_push, do_pop;

    assign do_push = i_ctl.push && (r_count != CW'(DEPTH));
    assign do_pop  = i_ctl.pop && (r_count != '0);

    always_comb begin
        n_rd_ptr = r_rd_ptr;
        n_wr_ptr = r_wr_ptr;
        n_count  = r_count;
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
        end
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CW'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ptr <= '0;
            r_wr_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_rd_ptr <= n_rd_ptr;
            r_wr_ptr <= n_wr_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_wr_entry;
        end
    end

    // forward a write that lands on the next head slot
    always_ff @(posedge i_clk) begin
        if (do_push && (r_wr_ptr == n_rd_ptr)) begin
            r_head <= i_wr_entry;
        end else begin
            r_head <= r_mem[n_rd_ptr];
        end
    end

    assign o_head  = r_head;
    assign o_count = r_count;

endmodule

[sv/wosa_rr_pick.sv]
// ----------------------------------------------------------------------------
// Wormhole output stage round-robin pick
// Finds the first requesting port after the last one served.
// ----------------------------------------------------------------------------
module wosa_rr_pick
    import wosa_pkg::*;
#(
    parameter int NUM_INPUTS = NUM_INPUTS_DEF,
    localparam int PW = $clog2(NUM_INPUTS)
) (
    input  logic [PW-1:0]         i_last,
    input  logic [NUM_INPUTS-1:0] i_req,
    output logic                  o_found,
    output logic [PW-1:0]         o_idx
);

    int idx;

    always_comb begin
        o_found = 1'b0;
        o_idx   = '0;
        idx     = 0;
        for (int i = NUM_INPUTS - 1; i >= 0; i--) begin
            idx = int'(i_last) + 1 + i;
            if (idx >= NUM_INPUTS) begin
                idx = idx - NUM_INPUTS;
            end
            if (i_req[idx]) begin
                o_found = 1'b1;
                o_idx   = PW'(idx);
            end
        end
    end

endmodule

[sv/wormhole_output_stage_arbiter.sv]
// ----------------------------------------------------------------------------
// Wormhole output stage arbiter
// Per-port flit queues feeding one output link with packet hold and
// round-robin selection; stop mask and header tracking per input port.
// ----------------------------------------------------------------------------
// Channel | Direction | Handshake              | Payload
// in      | input     | i_in_valid / o_in_stall | i_in_data  (t_in)
// out     | output    | o_out_valid/ i_out_stall| o_out_data (t_out)
// cfg     | input     | i_cfg_we               | i_cfg_idx, i_cfg_data
//
// One transaction per cycle sustained while i_out_stall is low; a transaction
// is taken into the input register, then its result into the result register.
// The queue head registers are read ahead, so the decision is combinational.
// Synchronous active-low reset empties all queues and clears the hold state.
// A stalled result holds; the input register still takes one more transaction.
// ----------------------------------------------------------------------------
module wormhole_output_stage_arbiter
    import wosa_pkg::*;
#(
    parameter int NUM_INPUTS  = NUM_INPUTS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int DATA_WIDTH  = DATA_WIDTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_in        i_in_data,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_out       o_out_data,
    input  logic       i_cfg_we,
    input  logic [0:0] i_cfg_idx,
    input  logic [3:0] i_cfg_data
);

`include "wormhole_output_stage_arbiter_macros.svh"

    localparam int PW = $clog2(NUM_INPUTS);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int EW = DATA_WIDTH + 2;
    localparam int MASK_PORTS = (NUM_INPUTS < 4) ? NUM_INPUTS : 4;

    logic                  r_in_valid;
    t_in                   r_in;
    logic                  r_out_valid;
    t_out                  r_out, n_out;
    logic [3:0]            r_pkt_len;
    logic                  r_local;
    logic [4:0]            r_hdr [NUM_INPUTS];
    logic [4:0]            n_hdr [NUM_INPUTS];
    logic [PW-1:0]         r_last, n_last;
    logic                  r_in_packet, n_in_packet;
    logic [3:0]            r_stop, n_stop;

    logic                  adv;
    logic [NUM_INPUTS-1:0] push, pop, nonempty;
    t_fifo_ctl             ctl [NUM_INPUTS];
    logic [EW-1:0]         head [NUM_INPUTS];
    logic [CW-1:0]         cnt [NUM_INPUTS];
    logic [CW-1:0]         cnt_after [NUM_INPUTS];
    logic [EW-1:0]         wr_entry;
    logic [PW-1:0]         pidx, src, rr_idx;
    logic                  in_range, rr_found, sent, ovf;

    assign adv        = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !adv;
    assign wr_entry   = {DATA_WIDTH'(r_in.flit_data), r_in.flit_kind};
    assign pidx       = PW'(r_in.port);
    assign in_range   = int'(r_in.port) < NUM_INPUTS;

    for (genvar g = 0; g < NUM_INPUTS; g++) begin : g_port
        assign ctl[g].push = push[g] && adv;
        assign ctl[g].pop  = pop[g] && adv;
        assign nonempty[g] = cnt[g] != '0;
        assign cnt_after[g] = cnt[g] - CW'(pop[g]);

        wosa_fifo #(
            .DEPTH      (QUEUE_DEPTH),
            .DATA_WIDTH (DATA_WIDTH)
        ) u_fifo (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (ctl[g]),
            .i_wr_entry (wr_entry),
            .o_head     (head[g]),
            .o_count    (cnt[g])
        );
    end

    wosa_rr_pick #(
        .NUM_INPUTS (NUM_INPUTS)
    ) u_rr_pick (
        .i_last  (r_last),
        .i_req   (nonempty),
        .o_found (rr_found),
        .o_idx   (rr_idx)
    );

    always_comb begin
        push        = '0;
        pop         = '0;
        n_hdr       = r_hdr;
        n_last      = r_last;
        n_in_packet = r_in_packet;
        n_stop      = r_stop;
        sent        = 1'b0;
        src         = '0;
        ovf         = 1'b0;
        if (r_in.action == ACT_ARRIVAL) begin
            if (in_range) begin
                if (cnt[pidx] == CW'(QUEUE_DEPTH)) begin
                    ovf = 1'b1;
                end else begin
                    push[pidx] = 1'b1;
                    if (r_in.flit_kind[KIND_HEAD_BIT] && (r_hdr[pidx] != HDR_MAX)) begin
                        n_hdr[pidx] = r_hdr[pidx] + 5'd1;
                    end
                end
            end
        end else begin
            if (r_in_packet) begin
                if (nonempty[r_last]) begin
                    sent        = 1'b1;
                    src         = r_last;
                    n_in_packet = !head[r_last][KIND_TAIL_BIT];
                end
            end else if (!r_in.downstream_stop && rr_found) begin
                sent        = 1'b1;
                src         = rr_idx;
                n_last      = rr_idx;
                n_in_packet = !head[rr_idx][KIND_TAIL_BIT];
            end
            if (sent) begin
                pop[src] = 1'b1;
                if (head[src][KIND_HEAD_BIT] && (r_hdr[src] != '0)) begin
                    n_hdr[src] = r_hdr[src] - 5'd1;
                end
            end
            n_stop = '0;
            for (int p = 0; p < MASK_PORTS; p++) begin
                n_stop[p] = (QUEUE_DEPTH - int'(cnt_after[p])) <= (int'(r_pkt_len) + 1);
            end
        end
    end

    always_comb begin
        n_out           = '0;
        n_out.out_valid = sent;
        if (sent) begin
            n_out.out_port = 2'(src);
            n_out.out_kind = head[src][1:0];
            n_out.out_data = 32'(head[src][EW-1:2]);
        end
        n_out.stop_mask              = n_stop;
        n_out.port_can_accept_packet = r_local || !in_range || (n_hdr[pidx] == '0);
        n_out.overflow               = ovf;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_pkt_len   <= PKT_LEN_RST;
            r_local     <= 1'b0;
            r_last      <= '0;
            r_in_packet <= 1'b0;
            r_stop      <= '0;
            for (int p = 0; p < NUM_INPUTS; p++) begin
                r_hdr[p] <= '0;
            end
        end else begin
            if (i_in_valid && !o_in_stall) begin
                r_in_valid <= 1'b1;
            end else if (adv) begin
                r_in_valid <= 1'b0;
            end
            if (adv) begin
                r_out_valid <= 1'b1;
                r_last      <= n_last;
                r_in_packet <= n_in_packet;
                r_stop      <= n_stop;
                r_hdr       <= n_hdr;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_PACKET_LENGTH:   r_pkt_len <= i_cfg_data;
                    CFG_LOCAL_DIRECTION: r_local   <= i_cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in <= i_in_data;
        end
        if (adv) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `WOSA_ASSERT_NOW(a_single_pop, 1'b1, $onehot0(pop), "more than one queue popped")
    `WOSA_ASSERT_NOW(a_no_push_and_pop, 1'b1, !((|push) && (|pop)), "push and pop together")
    `WOSA_ASSERT_NEXT(a_result_follows, adv, o_out_valid, "processed transaction lost")
    `WOSA_ASSERT_NEXT(a_hold_stable, !(adv && (r_in.action == ACT_TICK)),
        $stable(r_in_packet) && $stable(r_last), "packet hold changed without a tick")

endmodule
